// File: src/fbs_pkg.sv
package fbs_pkg;

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_SCAN  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic [9:0] CFG_DIM_RESET = 10'd512;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] pos_x;
        logic [8:0] pos_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       outside_frame;
        logic       scan_last;
    } out_item_t;

    // Stored pixel, red in the low byte
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_ITEM,
        ADDR_SCAN,
        ADDR_ZERO,
        ADDR_INC
    } addr_op_t;

    typedef struct packed {
        logic     item_load;
        addr_op_t addr_op;
        logic     scan_prep;
        logic     div_start;
        logic     scan_load_div;
        logic     mem_read;
        logic     mix_load;
        logic     mem_write;
        logic     out_load;
        logic     scan_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       in_frame;
        logic       opaque;
        logic       scan_pos_ok;
        logic       div_busy;
        logic       clr_last;
    } dp_status_t;

endpackage

// File: src/fbs_div.sv
module fbs_div #(
    parameter int NW = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [NW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient,
    output logic [NW-1:0] remainder
);

    localparam int CNTW = $clog2(NW + 1);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   quo_reg;
    logic [NW-1:0]   rem_reg;
    logic [NW-1:0]   dsr_reg;
    logic [NW:0]     shifted;
    logic            fits;

    // one quotient bit a cycle, restoring form
    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], fits};
            rem_reg <= fits ? NW'(shifted - {1'b0, dsr_reg}) : shifted[NW-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// File: src/fbs_datapath.sv
module fbs_datapath #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [9:0]            cfg_data,
    input  fbs_pkg::in_item_t     item,
    input  fbs_pkg::ctrl_cmd_t    cmd,
    output fbs_pkg::dp_status_t   status,
    output fbs_pkg::out_item_t    result
);

    import fbs_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int NW    = ($clog2(DEPTH + 1) > 10) ? $clog2(DEPTH + 1) : 10;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [9:0]      width_cfg_reg;
    logic [9:0]      height_cfg_reg;
    logic [NW-1:0]   w_sat;
    logic [NW-1:0]   h_sat;
    logic [2*NW-1:0] total_prod;
    logic [NW-1:0]   total_reg;

    in_item_t        item_reg;
    logic [NW-1:0]   addr_reg;
    logic [NW-1:0]   addr_next;
    logic [NW-1:0]   mul_a;
    logic [NW-1:0]   mul_c;
    logic [2*NW-1:0] addr_prod;
    logic            in_frame;

    logic [NW-1:0]   scan_k_reg;
    logic [NW-1:0]   scan_col_reg;
    logic [NW-1:0]   scan_row_reg;
    logic            scan_ok_reg;
    logic            scan_wrap;
    logic            scan_last;

    logic            div_busy;
    logic [NW-1:0]   div_quo;
    logic [NW-1:0]   div_rem;

    pixel_t          mem [DEPTH];
    pixel_t          rd_data_reg;
    pixel_t          wr_data;
    pixel_t          item_px;
    logic [15:0]     mix_reg [3];
    logic            opaque;

    out_item_t       out_reg;

    function automatic logic [15:0] mix_sum(input logic [7:0] src, input logic [7:0] dst,
                                            input logic [7:0] a);
        mix_sum = 16'(src) * 16'(a) + 16'(dst) * 16'(ALPHA_OPAQUE - a);
    endfunction

    // exact floor(n / 255) for any n up to 255*255, the largest blend sum
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = 17'(n) + 17'(n[15:8]) + 17'd1;
        div255 = t[15:8];
    endfunction

    // ---- configuration and frame size ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_DIM_RESET;
            height_cfg_reg <= CFG_DIM_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_cfg_reg <= cfg_data;
            end
            else
            begin
                height_cfg_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (width_cfg_reg == '0)
            w_sat = NW'(1);
        else if (NW'(width_cfg_reg) > NW'(MAX_WIDTH))
            w_sat = NW'(MAX_WIDTH);
        else
            w_sat = NW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            h_sat = NW'(1);
        else if (NW'(height_cfg_reg) > NW'(MAX_HEIGHT))
            h_sat = NW'(MAX_HEIGHT);
        else
            h_sat = NW'(height_cfg_reg);
    end

    assign total_prod = w_sat * h_sat;

    always_ff @(posedge clk)
    begin
        total_reg <= total_prod[NW-1:0];
    end

    // ---- item and address ----
    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            item_reg <= item;
        end
    end

    assign in_frame = (NW'(item_reg.pos_x) < w_sat) && (NW'(item_reg.pos_y) < h_sat);
    assign opaque   = item_reg.in_alpha == ALPHA_OPAQUE;

    assign mul_a     = (cmd.addr_op == ADDR_SCAN) ? (h_sat - NW'(1) - scan_row_reg)
                                                  : NW'(item_reg.pos_y);
    assign mul_c     = (cmd.addr_op == ADDR_SCAN) ? scan_col_reg : NW'(item_reg.pos_x);
    assign addr_prod = mul_a * w_sat;

    always_comb
    begin
        case (cmd.addr_op)
            ADDR_ITEM, ADDR_SCAN: addr_next = addr_prod[NW-1:0] + mul_c;
            ADDR_ZERO:            addr_next = '0;
            ADDR_INC:             addr_next = addr_reg + NW'(1);
            default:              addr_next = addr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    // ---- scan position ----
    assign scan_wrap = scan_k_reg >= total_reg;
    assign scan_last = scan_k_reg == total_reg - NW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_k_reg   <= '0;
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            scan_ok_reg  <= 1'b1;
        end
        else if (cfg_we && cfg_index == CFG_WIDTH)
        begin
            // column and row no longer match the index
            scan_ok_reg <= 1'b0;
        end
        else if (cmd.scan_prep && scan_wrap)
        begin
            scan_k_reg   <= '0;
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            scan_ok_reg  <= 1'b1;
        end
        else if (cmd.scan_load_div)
        begin
            scan_col_reg <= div_rem;
            scan_row_reg <= div_quo;
            scan_ok_reg  <= 1'b1;
        end
        else if (cmd.scan_step)
        begin
            if (scan_last)
            begin
                scan_k_reg   <= '0;
                scan_col_reg <= '0;
                scan_row_reg <= '0;
            end
            else
            begin
                scan_k_reg <= scan_k_reg + NW'(1);
                if (scan_col_reg == w_sat - NW'(1))
                begin
                    scan_col_reg <= '0;
                    scan_row_reg <= scan_row_reg + NW'(1);
                end
                else
                begin
                    scan_col_reg <= scan_col_reg + NW'(1);
                end
            end
        end
    end

    fbs_div #(
        .NW(NW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (scan_k_reg),
        .divisor  (w_sat),
        .busy     (div_busy),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    // ---- pixel store and blend ----
    assign item_px = '{alpha: item_reg.in_alpha, blue: item_reg.in_blue,
                       green: item_reg.in_green, red: item_reg.in_red};

    always_comb
    begin
        wr_data = item_px;
        if (item_reg.kind == KIND_WRITE && !opaque)
        begin
            wr_data.red   = div255(mix_reg[0]);
            wr_data.green = div255(mix_reg[1]);
            wr_data.blue  = div255(mix_reg[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[addr_reg[AW-1:0]] <= wr_data;
        end
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mix_load)
        begin
            mix_reg[0] <= mix_sum(item_reg.in_red,   rd_data_reg.red,   item_reg.in_alpha);
            mix_reg[1] <= mix_sum(item_reg.in_green, rd_data_reg.green, item_reg.in_alpha);
            mix_reg[2] <= mix_sum(item_reg.in_blue,  rd_data_reg.blue,  item_reg.in_alpha);
        end
    end

    // ---- result word ----
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (item_reg.kind == KIND_READ && !in_frame)
            begin
                out_reg <= '{out_red: 8'd0, out_green: 8'd0, out_blue: 8'd0,
                             out_alpha: 8'd0, outside_frame: 1'b1, scan_last: 1'b0};
            end
            else
            begin
                out_reg <= '{out_red: rd_data_reg.red, out_green: rd_data_reg.green,
                             out_blue: rd_data_reg.blue, out_alpha: rd_data_reg.alpha,
                             outside_frame: 1'b0,
                             scan_last: (item_reg.kind == KIND_SCAN) && scan_last};
            end
        end
    end

    assign result = out_reg;

    assign status = '{kind: item_reg.kind, in_frame: in_frame, opaque: opaque,
                      scan_pos_ok: scan_ok_reg || scan_wrap, div_busy: div_busy,
                      clr_last: addr_reg == total_reg - NW'(1)};

endmodule

// File: src/fbs_ctrl.sv
module fbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fbs_pkg::dp_status_t  status,
    output fbs_pkg::ctrl_cmd_t   cmd,
    output logic                 busy,
    output logic                 done
);

    import fbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_RUN,
        S_SCAN_ADDR,
        S_MEM_RD,
        S_BLEND,
        S_WRITE_BACK,
        S_CLR,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cmd        = '{addr_op: ADDR_HOLD, default: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.item_load = 1'b1;
                    busy_next     = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.kind)
                    KIND_WRITE:
                    begin
                        cmd.addr_op = ADDR_ITEM;
                        if (!status.in_frame)
                        begin
                            busy_next  = 1'b0;
                            state_next = S_IDLE;
                        end
                        else if (status.opaque)
                            state_next = S_WRITE_BACK;
                        else
                            state_next = S_MEM_RD;
                    end
                    KIND_READ:
                    begin
                        cmd.addr_op = ADDR_ITEM;
                        state_next  = status.in_frame ? S_MEM_RD : S_EMIT;
                    end
                    KIND_CLEAR:
                    begin
                        cmd.addr_op = ADDR_ZERO;
                        state_next  = S_CLR;
                    end
                    default:
                    begin
                        cmd.scan_prep = 1'b1;
                        if (status.scan_pos_ok)
                            state_next = S_SCAN_ADDR;
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV_RUN;
                        end
                    end
                endcase
            end
            S_DIV_RUN:
            begin
                if (!status.div_busy)
                begin
                    cmd.scan_load_div = 1'b1;
                    state_next        = S_SCAN_ADDR;
                end
            end
            S_SCAN_ADDR:
            begin
                cmd.addr_op = ADDR_SCAN;
                state_next  = S_MEM_RD;
            end
            S_MEM_RD:
            begin
                cmd.mem_read = 1'b1;
                state_next   = (status.kind == KIND_WRITE) ? S_BLEND : S_EMIT;
            end
            S_BLEND:
            begin
                cmd.mix_load = 1'b1;
                state_next   = S_WRITE_BACK;
            end
            S_WRITE_BACK:
            begin
                cmd.mem_write = 1'b1;
                busy_next     = 1'b0;
                state_next    = S_IDLE;
            end
            S_CLR:
            begin
                cmd.mem_write = 1'b1;
                cmd.addr_op   = ADDR_INC;
                if (status.clr_last)
                begin
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                cmd.out_load  = 1'b1;
                cmd.scan_step = status.kind == KIND_SCAN;
                done_next     = 1'b1;
                busy_next     = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// File: src/framebuffer_blend_store_top.sv
// RGBA8 frame store with source-over blending. Raise start while busy is low
// to hand in one word; busy then stays high until the item is finished and
// the next word may follow in the cycle busy drops. Read and scan items give
// one result word, shown on result for exactly one cycle with done high; the
// receiver cannot stall it, so capture it in that cycle. Write and clear give
// no word. Busy time after acceptance is set by the single-port pixel memory
// and its read-then-write sequence: an opaque write just stores, a blended
// write reads, multiplies, then divides and stores, a write outside the frame
// ends at decode, and a clear stores one pixel per cycle. After a width change
// the first scan item also runs a bit-serial divide to find its row and
// column, unless its position lies past the end of the new frame. The frame
// size registers are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while busy is low, as the block itself does not enforce
// it. Values out of range saturate to 1..MAX_WIDTH/MAX_HEIGHT. Pixels are
// undefined until a clear or write has set them.
module framebuffer_blend_store_top #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fbs_pkg::in_item_t   item,
    output logic                done,
    output fbs_pkg::out_item_t  result,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [9:0]          cfg_data
);

    import fbs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer: one item at a time, drives the datapath by command word.
    fbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .status(status),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Datapath: frame registers, address multiply, pixel memory, blend,
    // scan position and result register.
    fbs_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .item     (item),
        .cmd      (cmd),
        .status   (status),
        .result   (result)
    );

    // A result word only appears as the item finishes.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result word shown while still busy");

    // Each item gives at most one word, so done never repeats.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held for more than one cycle");

    // An accepted word always raises busy.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // An out-of-frame read reports zero color and no scan end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.outside_frame) |-> (result.out_red == 8'd0 &&
        result.out_green == 8'd0 && result.out_blue == 8'd0 &&
        result.out_alpha == 8'd0 && !result.scan_last))
        else $error("out-of-frame read returned a color");

endmodule

// File: tb/fbs_blend_checker.sv
`timescale 1ns / 1ps
module fbs_blend_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  fbs_pkg::in_item_t   item,
    input  logic                done,
    input  fbs_pkg::out_item_t  result,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [9:0]          cfg_data,
    output int                  mismatches,
    output int                  words_pending
);
    import fbs_pkg::*;

    localparam int FRAME_MAX_W = 512;
    localparam int FRAME_MAX_H = 512;

    pixel_t     frame_mem [FRAME_MAX_W * FRAME_MAX_H];
    logic [9:0] width_reg;
    logic [9:0] height_reg;
    int         scan_pos;
    int         fail_tally;
    out_item_t  pixel_words [$];
    out_item_t  oldest_word;

    // Saturate a frame size register to the range the store supports.
    function automatic int dim_in_use(logic [9:0] value, int limit);
        if (value == 10'd0)
            return 1;
        if (int'(value) > limit)
            return limit;
        return int'(value);
    endfunction

    function automatic logic [7:0] blend_channel(logic [7:0] src, logic [7:0] dst,
                                                 logic [7:0] alpha);
        int mixed;
        mixed = (int'(src) * int'(alpha)
                 + int'(dst) * (int'(ALPHA_OPAQUE) - int'(alpha))) / int'(ALPHA_OPAQUE);
        return mixed[7:0];
    endfunction

    function automatic out_item_t word_from_pixel(pixel_t px);
        out_item_t word;
        word = '0;
        word.out_red   = px.red;
        word.out_green = px.green;
        word.out_blue  = px.blue;
        word.out_alpha = px.alpha;
        return word;
    endfunction

    // Advance the store by one accepted word; queue the pixel word it yields.
    function automatic void apply_word(in_item_t w);
        int        fw;
        int        fh;
        int        total;
        int        addr;
        int        k;
        int        row;
        int        i;
        bit        in_frame;
        bit        last;
        pixel_t    px;
        out_item_t word;
        fw       = dim_in_use(width_reg, FRAME_MAX_W);
        fh       = dim_in_use(height_reg, FRAME_MAX_H);
        total    = fw * fh;
        in_frame = (int'(w.pos_x) < fw) && (int'(w.pos_y) < fh);
        addr     = int'(w.pos_y) * fw + int'(w.pos_x);
        case (w.kind)
            KIND_WRITE:
            begin
                if (in_frame)
                begin
                    px = {w.in_alpha, w.in_blue, w.in_green, w.in_red};
                    if (w.in_alpha != ALPHA_OPAQUE)
                    begin
                        px.red   = blend_channel(w.in_red, frame_mem[addr].red, w.in_alpha);
                        px.green = blend_channel(w.in_green, frame_mem[addr].green, w.in_alpha);
                        px.blue  = blend_channel(w.in_blue, frame_mem[addr].blue, w.in_alpha);
                    end
                    frame_mem[addr] = px;
                end
            end
            KIND_READ:
            begin
                if (in_frame)
                    word = word_from_pixel(frame_mem[addr]);
                else
                begin
                    word = '0;
                    word.outside_frame = 1'b1;
                end
                pixel_words.push_back(word);
            end
            KIND_CLEAR:
            begin
                px = {w.in_alpha, w.in_blue, w.in_green, w.in_red};
                for (i = 0; i < total; i++)
                    frame_mem[i] = px;
            end
            default:
            begin
                // scan: restart when the position fell past a shrunken frame
                k = scan_pos;
                if (k >= total)
                    k = 0;
                row  = (fh - 1) - k / fw;
                last = (k == total - 1);
                word = word_from_pixel(frame_mem[row * fw + k % fw]);
                word.scan_last = last;
                pixel_words.push_back(word);
                scan_pos = last ? 0 : k + 1;
            end
        endcase
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_tally++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = CFG_DIM_RESET;
            height_reg = CFG_DIM_RESET;
            scan_pos   = 0;
            fail_tally = 0;
            pixel_words.delete();
            mismatches    <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pixel_words.size() == 0)
                begin
                    $error("result word arrived with no pixel word expected");
                    fail_tally++;
                end
                else
                begin
                    oldest_word = pixel_words.pop_front();
                    check_field("out_red", oldest_word.out_red, result.out_red);
                    check_field("out_green", oldest_word.out_green, result.out_green);
                    check_field("out_blue", oldest_word.out_blue, result.out_blue);
                    check_field("out_alpha", oldest_word.out_alpha, result.out_alpha);
                    check_field("outside_frame", 8'(oldest_word.outside_frame),
                                8'(result.outside_frame));
                    check_field("scan_last", 8'(oldest_word.scan_last),
                                8'(result.scan_last));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end
            if (start && !busy)
                apply_word(item);
            mismatches    <= fail_tally;
            words_pending <= pixel_words.size();
        end
    end

endmodule

// File: tb/tb_framebuffer_blend_store_top.sv
`timescale 1ns / 1ps
module tb_framebuffer_blend_store_top;
    import fbs_pkg::*;

    // A full 512x512 clear holds busy while it stores every pixel, with nothing
    // accepted; allow several times that before calling the run hung.
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int FRAME_MAX       = 512;
    localparam int PHASES          = 12;
    localparam int WORDS_PER_PHASE = 160;
    // Frames above this size get no random clears.
    localparam int CLEAR_SIZE_CAP  = 4096;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      start     = 1'b0;
    logic      busy;
    in_item_t  item      = '0;
    logic      done;
    out_item_t result;
    logic      cfg_we    = 1'b0;
    logic      cfg_index = 1'b0;
    logic [9:0] cfg_data = '0;

    int mismatches;
    int words_pending;
    int stall_cycles = 0;

    // Frame size in use as the block sees it, and how many leading store
    // entries some clear has set so far. Reads and blended writes only touch
    // entries below y*w+x < w*h, so keep w*h within the cleared span.
    int frame_w      = FRAME_MAX;
    int frame_h      = FRAME_MAX;
    int cleared_span = 0;
    bit gaps_on      = 1'b1;

    // Register data per random phase: extremes, out-of-range values that
    // saturate, one full-size frame, and mostly small frames.
    int phase_w [PHASES] = '{8, 1, 0, 1023, 5, 16, 512, 3, 600, 64, 7, 2};
    int phase_h [PHASES] = '{8, 1, 1023, 0, 9, 2, 512, 1, 4, 40, 513, 3};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    framebuffer_blend_store_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fbs_blend_checker u_blend_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .done          (done),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .words_pending (words_pending)
    );

    // Watchdog: count cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int dim_in_use(int value);
        if (value < 1)
            return 1;
        if (value > FRAME_MAX)
            return FRAME_MAX;
        return value;
    endfunction

    // Hand one word to the block. Start is left high on return so that a
    // following word goes out back to back; drop it only to idle.
    task automatic send_word(in_item_t w);
        if (gaps_on)
        begin
            while ($urandom_range(0, 99) < 31)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        if (w.kind == KIND_CLEAR && frame_w * frame_h > cleared_span)
            cleared_span = frame_w * frame_h;
    endtask

    task automatic send_pixel_op(logic [1:0] kind, int x, int y,
                                 int red, int green, int blue, int alpha);
        in_item_t w;
        w.kind     = kind;
        w.pos_x    = x[8:0];
        w.pos_y    = y[8:0];
        w.in_red   = red[7:0];
        w.in_green = green[7:0];
        w.in_blue  = blue[7:0];
        w.in_alpha = alpha[7:0];
        send_word(w);
    endtask

    // Hold off until the block is idle and every pixel word has come back,
    // then idle on a little for writes and clears still settling.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (busy || words_pending != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Write the width register, then the height register; call only when idle.
    task automatic set_frame(int wdata, int hdata);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= wdata[9:0];
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= hdata[9:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        frame_w = dim_in_use(wdata);
        frame_h = dim_in_use(hdata);
    endtask

    // Random word: mostly in-frame positions, a bias toward opaque and edge
    // alphas, and every bit of every field free to toggle.
    function automatic in_item_t random_word(bit allow_clear);
        in_item_t    w;
        logic [63:0] bits;
        int          pick;
        bits = {$urandom(), $urandom()};
        w    = bits[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 40)
            w.kind = KIND_WRITE;
        else if (pick < 65)
            w.kind = KIND_READ;
        else if (pick < 95 || !allow_clear)
            w.kind = KIND_SCAN;
        else
            w.kind = KIND_CLEAR;
        if ($urandom_range(0, 99) < 80)
        begin
            w.pos_x = 9'($urandom_range(0, frame_w - 1));
            w.pos_y = 9'($urandom_range(0, frame_h - 1));
        end
        case ($urandom_range(0, 9))
            0, 1, 2: w.in_alpha = ALPHA_OPAQUE;
            3:       w.in_alpha = 8'd0;
            4:       w.in_alpha = 8'd254;
            5:       w.in_alpha = 8'd1;
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a 4x3 frame, cleared first so every entry is defined.
        set_frame(4, 3);
        send_pixel_op(KIND_CLEAR, 0, 0, 8'h11, 8'h22, 8'h33, 8'h44);
        send_pixel_op(KIND_READ, 0, 0, 0, 0, 0, 0);
        // opaque write stores as given
        send_pixel_op(KIND_WRITE, 3, 2, 8'hff, 8'hff, 8'hff, 8'hff);
        send_pixel_op(KIND_READ, 3, 2, 0, 0, 0, 0);
        // alpha zero keeps the stored color, takes the new alpha
        send_pixel_op(KIND_WRITE, 0, 0, 8'hff, 8'hff, 8'hff, 0);
        send_pixel_op(KIND_READ, 0, 0, 0, 0, 0, 0);
        // nearly opaque and nearly transparent blends
        send_pixel_op(KIND_WRITE, 1, 0, 8'hff, 8'h00, 8'h80, 254);
        send_pixel_op(KIND_READ, 1, 0, 0, 0, 0, 0);
        send_pixel_op(KIND_WRITE, 2, 1, 8'h00, 8'hff, 8'h7f, 1);
        send_pixel_op(KIND_READ, 2, 1, 0, 0, 0, 0);
        // write just past the right edge must be dropped, not wrapped
        send_pixel_op(KIND_WRITE, 4, 0, 8'h00, 8'h00, 8'h00, 8'hff);
        // reads outside the frame flag it and return zero color
        send_pixel_op(KIND_READ, 511, 511, 0, 0, 0, 0);
        send_pixel_op(KIND_READ, 0, 3, 0, 0, 0, 0);
        // one full scan pass with its last pixel, then wrap to the start
        repeat (13)
            send_pixel_op(KIND_SCAN, 0, 0, 0, 0, 0, 0);

        // Random phases, each at its own frame size.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_frame(phase_w[p], phase_h[p]);
            // leave two phases with no idling at all
            gaps_on = !(p == 4 || p == 5);
            if (frame_w * frame_h > cleared_span)
                send_pixel_op(KIND_CLEAR, 0, 0, $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // once, hold the sender until every pixel word is back
                if (p == 1 && n == WORDS_PER_PHASE / 2)
                    drain();
                send_word(random_word(frame_w * frame_h <= CLEAR_SIZE_CAP));
            end
        end

        drain();
        repeat (20)
            @(posedge clk);
        if (mismatches == 0 && words_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
